/* rtl/rrp_pkg.sv */
// Package for the receive rate pacer: field widths, register indexes,
// status codes and divider handshake types. No dependencies.
package rrp_pkg;

   localparam int BYTES_W     = 21;
   localparam int ELAPSED_W   = 40;
   localparam int TOTAL_W     = 48;
   localparam int PAUSE_W     = 20;
   localparam int RATE_W      = 22;
   localparam int DUR_W       = 16;
   localparam int CHUNK_W     = 11;
   localparam int AHEAD_W     = TOTAL_W + 1;
   localparam int PROD_W      = AHEAD_W + PAUSE_W;
   localparam int DIVIDEND_W  = PROD_W - 7;
   localparam int MUL_SPLIT   = 25;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 72;
   localparam int CSR_ADDR_W  = 2;

   localparam logic [PAUSE_W-1:0] US_PER_S = PAUSE_W'(1000000);

   localparam logic [CSR_ADDR_W-1:0] CSR_RATE     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DURATION = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHUNK    = 2'd2;

   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_DURATION = 2'd1,
      STATUS_FAILED   = 2'd2
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/rrp_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on rrp_pkg.
module rrp_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rrp_pkg::DIVIDEND_W-1:0]      dividend,
   input  logic [rrp_pkg::RATE_W-1:0]          divisor,
   output logic [rrp_pkg::DIVIDEND_W-1:0]      quotient,
   output rrp_pkg::div_status_type             status
);

   localparam int CntW = $clog2(rrp_pkg::DIVIDEND_W);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [CntW-1:0]                   cnt_ff, cnt_in;
   logic [rrp_pkg::RATE_W-1:0]        rem_ff, rem_in;
   logic [rrp_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [rrp_pkg::RATE_W:0]          trial;
   logic                              ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[rrp_pkg::DIVIDEND_W-1]};
      ge      = trial >= {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(rrp_pkg::DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? rrp_pkg::RATE_W'(trial - {1'b0, divisor})
                     : trial[rrp_pkg::RATE_W-1:0];
         quo_in = {quo_ff[rrp_pkg::DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a run");
`endif

endmodule

/* rtl/receive_rate_pacer.sv */
// Top level of the receive rate pacer: sequencer, config registers, total,
// two-step constant multiply and output register. Depends on rrp_pkg, rrp_div.
//
//  channel  dir  fields (low bit up)
//  req      in   tdata: bytes_read[20:0], elapsed_us[60:21]; tuser: read_failed
//  rsp      out  tdata: pause_us[19:0], total_bytes[67:20]; tuser: status
//  csr      in   csr_addr 0 rate_kibps, 1 duration_seconds, 2 chunk_kib
//
// A paced word passes through prep, the two-step multiply, the one-bit-per-cycle
// divider, a difference and a cap. Failed reads go straight to the output state;
// stops and zero rate go there after prep. One word is in work at a time; the
// next is taken the cycle after the result is loaded. A stalled result holds
// the sequencer in its output state. Synchronous reset restores control, the
// total and the config registers.
module receive_rate_pacer #(
   parameter int unsigned MAX_PAUSE_US = 1000000
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rrp_pkg::REQ_DATA_W-1:0]      req_tdata,  // bytes_read, elapsed_us
   input  logic                                req_tuser,  // read_failed
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rrp_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // pause_us, total_bytes
   output logic [1:0]                          rsp_tuser,  // status
   input  logic                                csr_we,
   input  logic [rrp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [rrp_pkg::RATE_W-1:0]          csr_wdata
);

   localparam logic [rrp_pkg::DIVIDEND_W-1:0] MaxPause =
      rrp_pkg::DIVIDEND_W'(MAX_PAUSE_US);
   localparam int HiW = rrp_pkg::AHEAD_W - rrp_pkg::MUL_SPLIT;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_PREP   = 9'b000000010,
      S_MULLO  = 9'b000000100,
      S_MULHI  = 9'b000001000,
      S_DSTART = 9'b000010000,
      S_DWAIT  = 9'b000100000,
      S_DIFF   = 9'b001000000,
      S_CAP    = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   state_type                             state_ff, state_in;
   logic [rrp_pkg::RATE_W-1:0]            rate_ff, rate_in;
   logic [rrp_pkg::DUR_W-1:0]             dur_ff, dur_in;
   logic [rrp_pkg::CHUNK_W-1:0]           chunk_ff, chunk_in;
   logic [rrp_pkg::TOTAL_W-1:0]           total_ff, total_in;
   logic [rrp_pkg::ELAPSED_W-1:0]         elapsed_ff, elapsed_in;
   logic [rrp_pkg::AHEAD_W-1:0]           ahead_ff, ahead_in;
   logic [rrp_pkg::PROD_W-1:0]            prod_ff, prod_in;
   logic [rrp_pkg::DIVIDEND_W-1:0]        diff_ff, diff_in;
   logic                                  late_ff, late_in;
   logic [rrp_pkg::PAUSE_W-1:0]           pause_ff, pause_in;
   rrp_pkg::status_type                   status_ff, status_in;
   logic                                  out_valid_ff, out_valid_in;
   logic [rrp_pkg::PAUSE_W-1:0]           out_pause_ff, out_pause_in;
   logic [rrp_pkg::TOTAL_W-1:0]           out_total_ff, out_total_in;
   rrp_pkg::status_type                   out_status_ff, out_status_in;

   logic                                  accept;
   logic                                  out_free;
   logic [rrp_pkg::TOTAL_W:0]             sum;
   logic [rrp_pkg::BYTES_W-1:0]           req_bytes;
   logic [35:0]                           dur_us;
   logic [rrp_pkg::DIVIDEND_W-1:0]        quotient;
   logic [rrp_pkg::DIVIDEND_W-1:0]        elapsed_ext;
   rrp_pkg::div_status_type               div_sts;

   rrp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DSTART),
      .dividend (prod_ff[rrp_pkg::PROD_W-1:7]),
      .divisor  (rate_ff),
      .quotient (quotient),
      .status   (div_sts)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      req_bytes   = req_tdata[rrp_pkg::BYTES_W-1:0];
      sum         = {1'b0, total_ff} + (rrp_pkg::TOTAL_W+1)'(req_bytes);
      dur_us      = 36'(dur_ff) * 36'(rrp_pkg::US_PER_S);
      elapsed_ext = rrp_pkg::DIVIDEND_W'(elapsed_ff);

      state_in      = state_ff;
      rate_in       = rate_ff;
      dur_in        = dur_ff;
      chunk_in      = chunk_ff;
      total_in      = total_ff;
      elapsed_in    = elapsed_ff;
      ahead_in      = ahead_ff;
      prod_in       = prod_ff;
      diff_in       = diff_ff;
      late_in       = late_ff;
      pause_in      = pause_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_pause_in  = out_pause_ff;
      out_total_in  = out_total_ff;
      out_status_in = out_status_ff;

      if (csr_we) begin
         case (csr_addr)
            rrp_pkg::CSR_RATE:     rate_in  = csr_wdata;
            rrp_pkg::CSR_DURATION: dur_in   = csr_wdata[rrp_pkg::DUR_W-1:0];
            rrp_pkg::CSR_CHUNK:    chunk_in = csr_wdata[rrp_pkg::CHUNK_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               elapsed_in = req_tdata[rrp_pkg::BYTES_W +: rrp_pkg::ELAPSED_W];
               pause_in   = '0;
               if (req_tuser) begin
                  status_in = rrp_pkg::STATUS_FAILED;
                  state_in  = S_OUT;
               end else begin
                  total_in = sum[rrp_pkg::TOTAL_W] ? '1 : sum[rrp_pkg::TOTAL_W-1:0];
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            ahead_in = rrp_pkg::AHEAD_W'(total_ff) + rrp_pkg::AHEAD_W'({chunk_ff, 10'b0});
            if (elapsed_ff >= rrp_pkg::ELAPSED_W'(dur_us)) begin
               status_in = rrp_pkg::STATUS_DURATION;
               state_in  = S_OUT;
            end else begin
               status_in = rrp_pkg::STATUS_CONTINUE;
               state_in  = (rate_ff == '0) ? S_OUT : S_MULLO;
            end
         end
         S_MULLO: begin
            prod_in  = rrp_pkg::PROD_W'(45'(ahead_ff[rrp_pkg::MUL_SPLIT-1:0])
                       * 45'(rrp_pkg::US_PER_S));
            state_in = S_MULHI;
         end
         S_MULHI: begin
            prod_in  = prod_ff + (rrp_pkg::PROD_W'(44'(ahead_ff[rrp_pkg::AHEAD_W-1 -: HiW])
                       * 44'(rrp_pkg::US_PER_S)) << rrp_pkg::MUL_SPLIT);
            state_in = S_DSTART;
         end
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_sts.done) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            late_in  = quotient > elapsed_ext;
            diff_in  = quotient - elapsed_ext;
            state_in = S_CAP;
         end
         S_CAP: begin
            if (late_ff) begin
               pause_in = (diff_ff > MaxPause) ? MaxPause[rrp_pkg::PAUSE_W-1:0]
                                               : diff_ff[rrp_pkg::PAUSE_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_pause_in  = pause_ff;
               out_total_in  = total_ff;
               out_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rate_ff      <= '0;
         dur_ff       <= rrp_pkg::DUR_W'(10);
         chunk_ff     <= rrp_pkg::CHUNK_W'(10);
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         dur_ff       <= dur_in;
         chunk_ff     <= chunk_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
      elapsed_ff    <= elapsed_in;
      ahead_ff      <= ahead_in;
      prod_ff       <= prod_in;
      diff_ff       <= diff_in;
      late_ff       <= late_in;
      pause_ff      <= pause_in;
      status_ff     <= status_in;
      out_pause_ff  <= out_pause_in;
      out_total_ff  <= out_total_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_total_ff, out_pause_ff};
   assign rsp_tuser  = out_status_ff;

`ifndef SYNTHESIS
   a_div_done_waits: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> state_ff == S_DWAIT)
      else $error("divider result arrived outside the wait state");
   a_div_busy_waits: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> state_ff == S_DWAIT)
      else $error("divider running outside the wait state");
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> total_ff >= $past(total_ff))
      else $error("byte total went down");
   a_stop_no_pause: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != rrp_pkg::STATUS_CONTINUE |-> out_pause_ff == '0)
      else $error("pause given with a stop status");
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT && out_free |=> out_valid_ff && state_ff == S_IDLE)
      else $error("result not loaded");
`endif

endmodule

/* tb/receive_rate_pacer_tb.sv */
// Self-checking testbench for receive_rate_pacer: directed and random reads with
// random stalls on both streams, each result word checked against a local pacing model.
// Depends on rrp_pkg and receive_rate_pacer.
module receive_rate_pacer_tb;

   localparam int unsigned MAX_PAUSE   = 1000000;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam logic [79:0] US_PER_SEC  = 80'd1000000;

   typedef struct {
      logic [rrp_pkg::PAUSE_W-1:0] pause_us;
      rrp_pkg::status_type         status;
      logic [rrp_pkg::TOTAL_W-1:0] total_bytes;
   } pacing_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rrp_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           req_tuser  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rrp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                     rsp_tuser;
   logic                           csr_we     = 1'b0;
   logic [rrp_pkg::CSR_ADDR_W-1:0] csr_addr   = rrp_pkg::CSR_RATE;
   logic [rrp_pkg::RATE_W-1:0]     csr_wdata  = '0;

   // mirror of the block's registers and byte total
   logic [rrp_pkg::RATE_W-1:0]  rate_kibps    = '0;
   logic [rrp_pkg::DUR_W-1:0]   duration_s    = 16'd10;
   logic [rrp_pkg::CHUNK_W-1:0] chunk_kib     = 11'd10;
   logic [rrp_pkg::TOTAL_W-1:0] running_total = '0;

   pacing_type  pending_pacing[$];
   pacing_type  want;
   pacing_type  got;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned tx_idle_pct    = 0;
   int unsigned rx_stall_pct   = 0;
   int unsigned hold_left      = 0;

   receive_rate_pacer #(.MAX_PAUSE_US(MAX_PAUSE)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("receive_rate_pacer_tb: FAIL");
      $finish;
   end

   task automatic predict_pacing(input logic [rrp_pkg::BYTES_W-1:0] nbytes,
                                 input logic failed,
                                 input logic [rrp_pkg::ELAPSED_W-1:0] elapsed);
      pacing_type                res;
      logic [rrp_pkg::TOTAL_W:0] sum;
      logic [79:0]               ahead;
      logic [79:0]               due;
      logic [79:0]               wait_us;
      res.pause_us = '0;
      res.status   = rrp_pkg::STATUS_CONTINUE;
      if (failed) begin
         res.status = rrp_pkg::STATUS_FAILED;
      end else begin
         sum = {1'b0, running_total} + {28'b0, nbytes};
         running_total = sum[rrp_pkg::TOTAL_W] ? '1 : sum[rrp_pkg::TOTAL_W-1:0];
         if (80'(elapsed) >= 80'(duration_s) * US_PER_SEC) begin
            res.status = rrp_pkg::STATUS_DURATION;
         end else if (rate_kibps != 0) begin
            ahead = 80'(running_total) + 80'(chunk_kib) * 80'd1024;
            due   = ahead * US_PER_SEC / (80'(rate_kibps) * 80'd128);
            if (due > 80'(elapsed)) begin
               wait_us = due - 80'(elapsed);
               if (wait_us > 80'(MAX_PAUSE)) wait_us = 80'(MAX_PAUSE);
               res.pause_us = wait_us[rrp_pkg::PAUSE_W-1:0];
            end
         end
      end
      res.total_bytes = running_total;
      pending_pacing.push_back(res);
   endtask

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_read(input logic [rrp_pkg::BYTES_W-1:0] nbytes, input logic failed,
                            input logic [rrp_pkg::ELAPSED_W-1:0] elapsed);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b0, elapsed, nbytes};
      req_tuser  <= failed;
      do @(posedge clock); while (!req_tready);
      predict_pacing(nbytes, failed, elapsed);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_pacing.size() != 0) @(negedge clock);
   endtask

   task automatic write_config(input logic [rrp_pkg::RATE_W-1:0] rate,
                               input logic [rrp_pkg::RATE_W-1:0] dur,
                               input logic [rrp_pkg::RATE_W-1:0] chunk);
      csr_we    <= 1'b1;
      csr_addr  <= rrp_pkg::CSR_RATE;
      csr_wdata <= rate;
      @(negedge clock);
      csr_addr  <= rrp_pkg::CSR_DURATION;
      csr_wdata <= dur;
      @(negedge clock);
      csr_addr  <= rrp_pkg::CSR_CHUNK;
      csr_wdata <= chunk;
      @(negedge clock);
      csr_we     <= 1'b0;
      rate_kibps = rate;
      duration_s = dur[rrp_pkg::DUR_W-1:0];
      chunk_kib  = chunk[rrp_pkg::CHUNK_W-1:0];
   endtask

   task automatic random_config();
      logic [rrp_pkg::RATE_W-1:0] rate;
      logic [rrp_pkg::RATE_W-1:0] dur;
      logic [rrp_pkg::RATE_W-1:0] chunk;
      case ($urandom_range(9))
         0: rate = '0;
         1: rate = '1;
         2, 3: rate = rrp_pkg::RATE_W'($urandom_range(1, 100));
         4, 5, 6: rate = rrp_pkg::RATE_W'($urandom_range(100, 100000));
         default: rate = rrp_pkg::RATE_W'($urandom);
      endcase
      case ($urandom_range(9))
         7: dur = '0;
         8: dur = rrp_pkg::RATE_W'($urandom_range(1, 60));
         9: dur = rrp_pkg::RATE_W'($urandom_range(0, 65535));
         default: dur = rrp_pkg::RATE_W'(16'hFFFF);
      endcase
      case ($urandom_range(9))
         0: chunk = '0;
         1: chunk = rrp_pkg::RATE_W'(11'h7FF);
         2: chunk = rrp_pkg::RATE_W'(1024);
         3: chunk = rrp_pkg::RATE_W'(1);
         default: chunk = rrp_pkg::RATE_W'($urandom_range(1, 1024));
      endcase
      // junk above the register width must be dropped
      if ($urandom_range(3) == 0) dur[rrp_pkg::RATE_W-1:rrp_pkg::DUR_W] = 6'($urandom);
      if ($urandom_range(3) == 0) chunk[rrp_pkg::RATE_W-1:rrp_pkg::CHUNK_W] = 11'($urandom);
      write_config(rate, dur, chunk);
   endtask

   // a read that mostly follows the schedule of the current total
   task automatic send_paced_read();
      logic [rrp_pkg::BYTES_W-1:0]   nbytes;
      logic [rrp_pkg::ELAPSED_W-1:0] elapsed;
      logic [79:0]                   nominal;
      logic                          failed;
      failed = ($urandom_range(99) < 5);
      case ($urandom_range(9))
         5, 6: nbytes = rrp_pkg::BYTES_W'($urandom_range(0, 1048576));
         7: nbytes = '0;
         8: nbytes = rrp_pkg::BYTES_W'($urandom);
         9: nbytes = rrp_pkg::BYTES_W'($urandom_range(1, 4096));
         default: nbytes = {chunk_kib, 10'b0};
      endcase
      case ($urandom_range(9))
         7: begin
            nominal = 80'(duration_s) * US_PER_SEC + 80'($urandom_range(0, 4));
            elapsed = (nominal > 80'd2) ? rrp_pkg::ELAPSED_W'(nominal - 80'd2) : '0;
         end
         8: elapsed = rrp_pkg::ELAPSED_W'({$urandom, $urandom});
         9: elapsed = rrp_pkg::ELAPSED_W'($urandom_range(0, 1000000));
         default: begin
            if (rate_kibps != 0)
               nominal = 80'(running_total) * US_PER_SEC / (80'(rate_kibps) * 80'd128);
            else
               nominal = 80'($urandom_range(0, 20000000));
            nominal = nominal + 80'($urandom_range(0, 3000000));
            elapsed = (nominal > 80'd2000000) ?
                      rrp_pkg::ELAPSED_W'(nominal - 80'd2000000) : '0;
         end
      endcase
      send_read(nbytes, failed, elapsed);
   endtask

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.pause_us    = rsp_tdata[rrp_pkg::PAUSE_W-1:0];
         got.total_bytes = rsp_tdata[rrp_pkg::PAUSE_W+rrp_pkg::TOTAL_W-1:rrp_pkg::PAUSE_W];
         got.status      = rrp_pkg::status_type'(rsp_tuser);
         if (pending_pacing.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: pause %0d status %0d total %0d",
                        got.pause_us, got.status, got.total_bytes);
         end else begin
            want = pending_pacing.pop_front();
            if (got.pause_us !== want.pause_us || got.status !== want.status ||
                got.total_bytes !== want.total_bytes) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected pause %0d status %0d total %0d,",
                           want.pause_us, want.status, want.total_bytes,
                           " got pause %0d status %0d total %0d",
                           got.pause_us, got.status, got.total_bytes);
            end
         end
      end
   end

   // registers still at reset: no pacing, 10 s session
   task automatic test_default_registers();
      send_read(21'd1000, 1'b0, 40'd0);
      send_read(21'd0, 1'b0, 40'd9999999);
      send_read(21'd1048576, 1'b0, 40'd10000000);
      send_read(21'h1FFFFF, 1'b1, 40'd0);
      send_read(21'd5, 1'b0, 40'd0);
      drain();
   endtask

   task automatic test_pacing_extremes();
      write_config(rrp_pkg::RATE_W'(80), rrp_pkg::RATE_W'(65535), rrp_pkg::RATE_W'(10));
      send_read(21'd0, 1'b0, 40'd0);
      send_read(21'd1048576, 1'b0, 40'd1);
      send_read(21'h1FFFFF, 1'b1, '1);
      send_read(21'd12345, 1'b0, '1);
      send_read(21'd0, 1'b0, 40'd60000000000);
      drain();
      write_config('1, rrp_pkg::RATE_W'(65535), rrp_pkg::RATE_W'(11'h7FF));
      send_read(21'd1048576, 1'b0, 40'd0);
      send_read(21'd0, 1'b0, 40'd5000);
      drain();
      write_config(rrp_pkg::RATE_W'(1), rrp_pkg::RATE_W'(0), rrp_pkg::RATE_W'(0));
      send_read(21'd100, 1'b0, 40'd0);
      send_read(21'd100, 1'b1, 40'd0);
      drain();
      write_config(rrp_pkg::RATE_W'(1), rrp_pkg::RATE_W'(65535), rrp_pkg::RATE_W'(0));
      send_read(21'd0, 1'b0, 40'd0);
      drain();
      write_config(rrp_pkg::RATE_W'(1000), rrp_pkg::RATE_W'(65535), rrp_pkg::RATE_W'(1024));
      send_read(21'd0, 1'b0, 40'd65534999999);
      send_read(21'd0, 1'b0, 40'd65535000000);
      drain();
   endtask

   task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int unsigned count);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            drain();
            random_config();
         end
         send_paced_read();
      end
      drain();
   endtask

   // receiver holds off while reads keep coming, so the input backs up
   task automatic test_receiver_holdoff();
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      write_config(rrp_pkg::RATE_W'(5000), rrp_pkg::RATE_W'(65535), rrp_pkg::RATE_W'(64));
      hold_left <= 400;
      for (int i = 0; i < 24; i++) send_paced_read();
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_default_registers();
      test_pacing_extremes();
      test_random_traffic(0, 0, 400);
      test_random_traffic(72, 0, 400);
      test_random_traffic(0, 72, 400);
      test_random_traffic(6, 6, 400);
      test_receiver_holdoff();
      drain();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0 && pending_pacing.size() == 0)
         $display("receive_rate_pacer_tb: PASS");
      else
         $display("receive_rate_pacer_tb: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/rrp_pkg.sv
rtl/rrp_div.sv
rtl/receive_rate_pacer.sv
tb/receive_rate_pacer_tb.sv
